FILE: hdl/heap_sweep_coalescer_unit_defines.svh
// Assertion macros shared by the heap sweep coalescer RTL.
`ifndef HEAP_SWEEP_COALESCER_UNIT_DEFINES_SVH
`define HEAP_SWEEP_COALESCER_UNIT_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define HSC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hsc: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define HSC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hsc: next-cycle check failed");

`else

`define HSC_ASSERT_NOW(lbl, ante, cons)
`define HSC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

FILE: hdl/hsc_pkg.sv
// Types and constants of the heap sweep coalescer.
package hsc_pkg;

  // Heap size in units; addresses span it, positions carry one more bit
  localparam int unsigned HEAP_UNITS = 65536;
  localparam int unsigned ADDR_W     = $clog2(HEAP_UNITS);
  localparam int unsigned POS_W      = ADDR_W + 1;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [POS_W-1:0]  len_t;
  typedef logic [1:0]        action_t;

  // Input beat kinds
  localparam logic MODE_BLOCK  = 1'b0;
  localparam logic MODE_FINISH = 1'b1;

  // Result actions
  localparam action_t ACT_KEEP   = 2'd0;
  localparam action_t ACT_NEW    = 2'd1;
  localparam action_t ACT_MERGE  = 2'd2;
  localparam action_t ACT_FINISH = 2'd3;

  typedef struct packed {
    logic mode;
    len_t blk_len;
    logic block_is_free;
    logic alive_mark;
    logic keep_alive_mark;
  } item_t;

  typedef struct packed {
    action_t action;
    addr_t   block_address;
    addr_t   link_address;
    logic    link_valid;
    len_t    new_length;
    len_t    heap_top;
    addr_t   free_head;
    logic    free_head_valid;
    addr_t   cut_address;
    logic    cut_valid;
    len_t    max_free_len;
  } result_t;

endpackage

FILE: hdl/hsc_in_if.sv
// Block header channel: valid/ready handshake with the header fields.
interface hsc_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  hsc_pkg::len_t      blk_len;
  logic               block_is_free;
  logic               alive_mark;
  logic               keep_alive_mark;

  modport source (output valid, mode, blk_len, block_is_free, alive_mark,
                  keep_alive_mark, input ready);
  modport sink   (input valid, mode, blk_len, block_is_free, alive_mark,
                  keep_alive_mark, output ready);
endinterface

FILE: hdl/hsc_out_if.sv
// Sweep result channel: valid/ready handshake with the result fields.
interface hsc_out_if;
  logic                 valid;
  logic                 ready;
  hsc_pkg::action_t     action;
  hsc_pkg::addr_t       block_address;
  hsc_pkg::addr_t       link_address;
  logic                 link_valid;
  hsc_pkg::len_t        new_length;
  hsc_pkg::len_t        heap_top;
  hsc_pkg::addr_t       free_head;
  logic                 free_head_valid;
  hsc_pkg::addr_t       cut_address;
  logic                 cut_valid;
  hsc_pkg::len_t        max_free_len;

  modport source (output valid, action, block_address, link_address, link_valid,
                  new_length, heap_top, free_head, free_head_valid, cut_address,
                  cut_valid, max_free_len, input ready);
  modport sink   (input valid, action, block_address, link_address, link_valid,
                  new_length, heap_top, free_head, free_head_valid, cut_address,
                  cut_valid, max_free_len, output ready);
endinterface

FILE: hdl/hsc_in_stage.sv
// Input register: captures one header beat and holds it until the core takes it.
module hsc_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  hsc_in_if.sink          in_ch,
  input  logic            take,
  output logic            item_valid,
  output hsc_pkg::item_t  item
);

  logic           full_r;
  logic           full_nxt;
  hsc_pkg::item_t item_r;
  logic           load;

  // Room when empty or when the held beat leaves this cycle
  assign in_ch.ready = !full_r || take;
  assign load        = in_ch.valid && in_ch.ready;

  always_comb begin
    full_nxt = full_r;
    if (load) begin
      full_nxt = 1'b1;
    end else if (take) begin
      full_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else begin
      full_r <= full_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      item_r.mode            <= in_ch.mode;
      item_r.blk_len         <= in_ch.blk_len;
      item_r.block_is_free   <= in_ch.block_is_free;
      item_r.alive_mark      <= in_ch.alive_mark;
      item_r.keep_alive_mark <= in_ch.keep_alive_mark;
    end
  end

  assign item_valid = full_r;
  assign item       = item_r;

endmodule

FILE: hdl/hsc_sweep_core.sv
// Sweep state and the per-beat keep / free / merge / finish decision.
`include "heap_sweep_coalescer_unit_defines.svh"

module hsc_sweep_core (
  input  logic             clk,
  input  logic             rst_n,
  input  hsc_pkg::addr_t   heap_start,
  input  logic             fire,
  input  hsc_pkg::item_t   item,
  output hsc_pkg::result_t result
);

  localparam int unsigned POS_W = hsc_pkg::POS_W;

  // Sweep state
  hsc_pkg::len_t  pos_r,      pos_nxt;
  hsc_pkg::addr_t lf_addr_r,  lf_addr_nxt;
  hsc_pkg::len_t  lf_len_r,   lf_len_nxt;
  logic           lf_v_r,     lf_v_nxt;
  hsc_pkg::addr_t bf_addr_r,  bf_addr_nxt;
  logic           bf_v_r,     bf_v_nxt;
  hsc_pkg::addr_t head_r,     head_nxt;
  logic           head_v_r,   head_v_nxt;
  hsc_pkg::len_t  live_end_r, live_end_nxt;
  hsc_pkg::len_t  largest_r,  largest_nxt;
  logic           live_seen_r, live_seen_nxt;
  logic           cut_pend_r,  cut_pend_nxt;
  logic           in_sweep_r,  in_sweep_nxt;

  hsc_pkg::len_t  start_pos;
  hsc_pkg::len_t  cur_pos;
  hsc_pkg::addr_t addr;
  hsc_pkg::len_t  lf_end;
  logic [POS_W:0] merged_sum;
  hsc_pkg::len_t  merged;
  hsc_pkg::len_t  top;
  logic           is_live;
  logic           adjoins;

  assign start_pos  = {1'b0, heap_start};
  assign cur_pos    = in_sweep_r ? pos_r : start_pos;
  assign addr       = cur_pos[POS_W-2:0];
  assign lf_end     = {1'b0, lf_addr_r} + lf_len_r;
  assign adjoins    = lf_v_r && (lf_end == cur_pos);
  assign merged_sum = {1'b0, lf_len_r} + {1'b0, item.blk_len};
  assign merged     = merged_sum[POS_W] ? '1 : merged_sum[POS_W-1:0];
  assign top        = live_seen_r ? live_end_r : start_pos;
  assign is_live    = !item.block_is_free && (item.alive_mark || item.keep_alive_mark);

  // Result and next state for the beat at the core's input
  always_comb begin
    result        = '0;
    pos_nxt       = pos_r;
    lf_addr_nxt   = lf_addr_r;
    lf_len_nxt    = lf_len_r;
    lf_v_nxt      = lf_v_r;
    bf_addr_nxt   = bf_addr_r;
    bf_v_nxt      = bf_v_r;
    head_nxt      = head_r;
    head_v_nxt    = head_v_r;
    live_end_nxt  = live_end_r;
    largest_nxt   = largest_r;
    live_seen_nxt = live_seen_r;
    cut_pend_nxt  = cut_pend_r;
    in_sweep_nxt  = in_sweep_r;

    if (item.mode == hsc_pkg::MODE_FINISH) begin
      result.action          = hsc_pkg::ACT_FINISH;
      result.heap_top        = top;
      result.free_head       = head_r;
      result.free_head_valid = head_v_r && ({1'b0, head_r} < top);
      result.cut_address     = bf_addr_r;
      result.cut_valid       = bf_v_r && cut_pend_r;
      result.max_free_len    = largest_r;
      // Back to start values for the next sweep
      pos_nxt       = start_pos;
      lf_addr_nxt   = '0;
      lf_len_nxt    = '0;
      lf_v_nxt      = 1'b0;
      bf_addr_nxt   = '0;
      bf_v_nxt      = 1'b0;
      head_nxt      = '0;
      head_v_nxt    = 1'b0;
      live_end_nxt  = start_pos;
      largest_nxt   = '0;
      live_seen_nxt = 1'b0;
      cut_pend_nxt  = 1'b0;
      in_sweep_nxt  = 1'b0;
    end else begin
      result.block_address = addr;
      in_sweep_nxt         = 1'b1;
      pos_nxt              = cur_pos + item.blk_len;
      priority if (is_live) begin
        result.action = hsc_pkg::ACT_KEEP;
        live_seen_nxt = 1'b1;
        live_end_nxt  = cur_pos + item.blk_len;
        bf_addr_nxt   = lf_addr_r;
        bf_v_nxt      = lf_v_r;
        cut_pend_nxt  = 1'b0;
      end else if (adjoins) begin
        result.action       = hsc_pkg::ACT_MERGE;
        result.link_address = lf_addr_r;
        result.link_valid   = 1'b1;
        result.new_length   = merged;
        lf_len_nxt          = merged;
        if (merged > largest_r) begin
          largest_nxt = merged;
        end
      end else begin
        result.action       = hsc_pkg::ACT_NEW;
        result.link_address = lf_v_r ? lf_addr_r : '0;
        result.link_valid   = lf_v_r;
        result.new_length   = item.blk_len;
        if (lf_v_r) begin
          if (bf_v_r && (bf_addr_r == lf_addr_r)) begin
            cut_pend_nxt = 1'b1;
          end
        end else begin
          head_nxt   = addr;
          head_v_nxt = 1'b1;
        end
        lf_addr_nxt = addr;
        lf_len_nxt  = item.blk_len;
        lf_v_nxt    = 1'b1;
        if (item.blk_len > largest_r) begin
          largest_nxt = item.blk_len;
        end
      end
      result.max_free_len = largest_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      lf_addr_r   <= '0;
      lf_len_r    <= '0;
      lf_v_r      <= 1'b0;
      bf_addr_r   <= '0;
      bf_v_r      <= 1'b0;
      head_r      <= '0;
      head_v_r    <= 1'b0;
      live_end_r  <= '0;
      largest_r   <= '0;
      live_seen_r <= 1'b0;
      cut_pend_r  <= 1'b0;
      in_sweep_r  <= 1'b0;
    end else if (fire) begin
      pos_r       <= pos_nxt;
      lf_addr_r   <= lf_addr_nxt;
      lf_len_r    <= lf_len_nxt;
      lf_v_r      <= lf_v_nxt;
      bf_addr_r   <= bf_addr_nxt;
      bf_v_r      <= bf_v_nxt;
      head_r      <= head_nxt;
      head_v_r    <= head_v_nxt;
      live_end_r  <= live_end_nxt;
      largest_r   <= largest_nxt;
      live_seen_r <= live_seen_nxt;
      cut_pend_r  <= cut_pend_nxt;
      in_sweep_r  <= in_sweep_nxt;
    end
  end

  // A pending cut always refers to a recorded free block before the live end
  `HSC_ASSERT_NOW(a_cut_needs_before, cut_pend_r, bf_v_r)
  // Largest free length only grows within a sweep
  `HSC_ASSERT_NEXT(a_largest_grows, fire && (item.mode == hsc_pkg::MODE_BLOCK),
                   largest_r >= $past(largest_r))
  // A finish beat leaves the engine ready for a fresh sweep
  `HSC_ASSERT_NEXT(a_finish_restarts, fire && (item.mode == hsc_pkg::MODE_FINISH),
                   !in_sweep_r && !lf_v_r && !head_v_r)

endmodule

FILE: hdl/heap_sweep_coalescer_unit.sv
// Heap sweep coalescer: block headers in, keep/free/merge/finish results out.
//
// Channels: in_ch takes one beat per block header in address order (mode 0)
// or a finish beat (mode 1); out_ch gives exactly one result beat per input
// beat, in order. cfg_we/cfg_wdata write heap_start, the address of the first
// block; write it only while the unit is idle. It applies from the next sweep.
// Pipeline: two register stages, input register then result register; a header
// held in the input register moves to the result register when that is free or draining.
// Throughput: one beat per cycle while out_ch is ready; the only loop is the running
// position and free-block state, updated by one add/compare step per beat.
// Stalls: while out_ch.ready is low the result register holds its beat, the
// input register holds one more, and in_ch.ready then drops until out_ch
// drains. in_ch.ready never waits on the whole sweep.
// Reset (rst_n low, synchronous): both stages empty, heap_start zero, sweep
// state back to its start values. No clearing pass is needed.
// A finish beat reports heap top, free-list head and the block whose next
// link must be cut, then starts a new sweep.
`include "heap_sweep_coalescer_unit_defines.svh"

module heap_sweep_coalescer_unit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  hsc_pkg::addr_t cfg_wdata,
  hsc_in_if.sink         in_ch,
  hsc_out_if.source      out_ch
);

  hsc_pkg::addr_t   heap_start_r;
  hsc_pkg::item_t   item;
  logic             item_valid;
  logic             fire;
  hsc_pkg::result_t result;
  hsc_pkg::result_t res_r;
  logic             out_v_r;
  logic             out_v_nxt;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_start_r <= '0;
    end else if (cfg_we) begin
      heap_start_r <= cfg_wdata;
    end
  end

  hsc_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .take       (fire),
    .item_valid (item_valid),
    .item       (item)
  );

  // Process the held beat when the result register is free or draining
  assign fire = item_valid && (!out_v_r || out_ch.ready);

  hsc_sweep_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .heap_start (heap_start_r),
    .fire       (fire),
    .item       (item),
    .result     (result)
  );

  // Result register
  always_comb begin
    out_v_nxt = out_v_r;
    if (fire) begin
      out_v_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= result;
    end
  end

  assign out_ch.valid           = out_v_r;
  assign out_ch.action          = res_r.action;
  assign out_ch.block_address   = res_r.block_address;
  assign out_ch.link_address    = res_r.link_address;
  assign out_ch.link_valid      = res_r.link_valid;
  assign out_ch.new_length      = res_r.new_length;
  assign out_ch.heap_top        = res_r.heap_top;
  assign out_ch.free_head       = res_r.free_head;
  assign out_ch.free_head_valid = res_r.free_head_valid;
  assign out_ch.cut_address     = res_r.cut_address;
  assign out_ch.cut_valid       = res_r.cut_valid;
  assign out_ch.max_free_len    = res_r.max_free_len;

  // A held beat with a free result slot is in the result register in the next cycle
  `HSC_ASSERT_NEXT(a_no_bubble, item_valid && !(out_v_r && !out_ch.ready), out_v_r)
  // A merge result always names the block that grew
  `HSC_ASSERT_NOW(a_merge_linked, out_v_r && (res_r.action == hsc_pkg::ACT_MERGE),
                  res_r.link_valid)
  // A stalled result beat stays offered
  `HSC_ASSERT_NEXT(a_out_held, out_v_r && !out_ch.ready, out_v_r)

endmodule
